[hw/rtl/b58d_pkg.sv]
// Shared constants, types and the alphabet lookup for the Base58 decoder.
// No dependencies; imported by b58d_dp, b58d_ctrl, the top level and the checker.
package b58d_pkg;

    localparam int OUT_BYTES = 64;
    localparam int MAX_CHARS = 88;
    localparam int MIN_CHARS = 64;
    localparam int ACC_WORDS = 8;
    localparam int CNT_W     = 7;
    localparam int IDX_W     = $clog2(ACC_WORDS);
    localparam int BYTE_W    = $clog2(OUT_BYTES);
    localparam int CARRY_W   = 6;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [7:0]       CHAR_ONE = 8'h31;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_CHAR = 3'd1;
    localparam logic [2:0] ST_BAD_LEN  = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_NONCANON = 3'd4;

    typedef logic [ACC_WORDS-1:0][63:0] acc_t;

    // controller -> datapath
    typedef struct packed {
        logic             load;
        logic             step;
        logic [IDX_W-1:0] step_idx;
        logic             shift;
        logic             clear;
        logic             show_ok;
        logic             show_err;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last;
        logic fail;
    } stat_t;

    // {valid, digit}: valid is 0 for bytes outside the alphabet
    function automatic logic [6:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        logic       v;
        d = 8'd0;
        v = 1'b1;
        if (c >= 8'h31 && c <= 8'h39)
            d = c - 8'h31;
        else if (c >= 8'h41 && c <= 8'h48)
            d = c - 8'h41 + 8'd9;
        else if (c >= 8'h4a && c <= 8'h4e)
            d = c - 8'h4a + 8'd17;
        else if (c >= 8'h50 && c <= 8'h5a)
            d = c - 8'h50 + 8'd22;
        else if (c >= 8'h61 && c <= 8'h6b)
            d = c - 8'h61 + 8'd33;
        else if (c >= 8'h6d && c <= 8'h7a)
            d = c - 8'h6d + 8'd44;
        else
            v = 1'b0;
        return {v, d[5:0]};
    endfunction

    // leading zero bytes of a nonzero 64-bit word (0..7)
    function automatic logic [2:0] lead_zero_bytes(input logic [63:0] w);
        logic [2:0] n;
        n = 3'd7;
        for (int i = 0; i < 8; i++)
        begin
            if (w[63-8*i -: 8] != 8'd0 && n == 3'd7 && i < 7)
                n = 3'(i);
        end
        if (w[63:56] != 8'd0)
            n = 3'd0;
        return n;
    endfunction

endpackage

[hw/rtl/base58_fixed64_decoder.sv]
// Top level of the Base58 decoder with a fixed 64-byte result.
// Depends on b58d_pkg, b58d_dp and b58d_ctrl.
//
// Input: one character beat per command. A beat (char_code, last_char) is taken
// at a rising edge where start is high and busy is low. Characters arrive most
// significant digit first; last_char marks the end of the string.
// Each beat runs the 512-bit value*58+digit update one 64-bit word per cycle;
// busy stays high at least until every word is updated, and no new beat is taken before then.
// Output: the word steps of the last beat are followed by a check state; in
// the cycle after it the block starts to show either 64 bytes on consecutive
// cycles (status 0, most significant byte first, last_of_run on the 64th) or
// one error beat with out_byte 0, a nonzero status and last_of_run set. Each
// result is valid for exactly one cycle while strobe is high; the receiver
// cannot stall it. busy stays high until the last result has been shown, then
// the state is cleared for the next string.
// Reset (rst_n low, asynchronous) clears the accumulator and all counters.
module base58_fixed64_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] char_code,
    input  logic       last_char,
    output logic       strobe,
    output logic [7:0] out_byte,
    output logic [2:0] status,
    output logic       last_of_run
);
    import b58d_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    b58d_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .stat        (stat),
        .cmd         (cmd),
        .busy        (busy),
        .strobe      (strobe),
        .last_of_run (last_of_run)
    );

    b58d_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_code (char_code),
        .last_char (last_char),
        .cmd       (cmd),
        .stat      (stat),
        .out_byte  (out_byte),
        .status    (status)
    );

endmodule

[hw/rtl/b58d_dp.sv]
// Datapath: 512-bit accumulator updated one 64-bit word per cycle, counters, checks.
// Depends on b58d_pkg.
module b58d_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         char_code,
    input  logic               last_char,
    input  b58d_pkg::cmd_t     cmd,
    output b58d_pkg::stat_t    stat,
    output logic [7:0]         out_byte,
    output logic [2:0]         status
);
    import b58d_pkg::*;

    acc_t               acc_reg, acc_next;
    logic [CARRY_W-1:0] carry_reg, carry_next;
    logic [CNT_W-1:0]   char_cnt_reg, char_cnt_next;
    logic [CNT_W-1:0]   lead_ones_reg, lead_ones_next;
    logic [CNT_W-1:0]   zcnt_reg, zcnt_next;
    logic               lead_run_reg, lead_run_next;
    logic               bad_char_reg, bad_char_next;
    logic               ovf_reg, ovf_next;
    logic               last_reg, last_next;

    logic [6:0]              dig;
    logic [64+CARRY_W-1:0]   wext, prod;
    logic [2:0]              code;

    assign dig  = digit_of(char_code);
    // word * 58 = word * (32 + 16 + 8 + 2)
    assign wext = {{CARRY_W{1'b0}}, acc_reg[0]};
    assign prod = (wext << 5) + (wext << 4) + (wext << 3) + (wext << 1)
                + {64'd0, carry_reg};

    always_comb
    begin
        acc_next       = acc_reg;
        carry_next     = carry_reg;
        char_cnt_next  = char_cnt_reg;
        lead_ones_next = lead_ones_reg;
        zcnt_next      = zcnt_reg;
        lead_run_next  = lead_run_reg;
        bad_char_next  = bad_char_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        if (cmd.clear)
        begin
            acc_next       = '0;
            carry_next     = '0;
            char_cnt_next  = '0;
            lead_ones_next = '0;
            zcnt_next      = '0;
            lead_run_next  = 1'b1;
            bad_char_next  = 1'b0;
            ovf_next       = 1'b0;
            last_next      = 1'b0;
        end
        else if (cmd.load)
        begin
            carry_next = dig[5:0];
            zcnt_next  = CNT_W'(OUT_BYTES);
            last_next  = last_char;
            if (!dig[6])
                bad_char_next = 1'b1;
            if (char_cnt_reg != CNT_MAX)
                char_cnt_next = char_cnt_reg + 1'b1;
            if (lead_run_reg && char_code == CHAR_ONE)
            begin
                if (lead_ones_reg != CNT_MAX)
                    lead_ones_next = lead_ones_reg + 1'b1;
            end
            else
                lead_run_next = 1'b0;
        end
        else if (cmd.step)
        begin
            // words pass low to high; new word enters at the top, ring restores order
            acc_next   = {prod[63:0], acc_reg[ACC_WORDS-1:1]};
            carry_next = prod[64+CARRY_W-1:64];
            if (cmd.step_idx == IDX_W'(ACC_WORDS - 1) && prod[64+CARRY_W-1:64] != '0)
                ovf_next = 1'b1;
            if (prod[63:0] != 64'd0)
                zcnt_next = {1'b0, ~cmd.step_idx, 3'b000} + {4'd0, lead_zero_bytes(prod[63:0])};
        end
        else if (cmd.shift)
        begin
            acc_next = acc_reg << 8;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            carry_reg     <= '0;
            char_cnt_reg  <= '0;
            lead_ones_reg <= '0;
            zcnt_reg      <= '0;
            lead_run_reg  <= 1'b1;
            bad_char_reg  <= 1'b0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            carry_reg     <= carry_next;
            char_cnt_reg  <= char_cnt_next;
            lead_ones_reg <= lead_ones_next;
            zcnt_reg      <= zcnt_next;
            lead_run_reg  <= lead_run_next;
            bad_char_reg  <= bad_char_next;
            ovf_reg       <= ovf_next;
            last_reg      <= last_next;
        end
    end

    always_comb
    begin
        priority if (char_cnt_reg < CNT_W'(MIN_CHARS) || char_cnt_reg > CNT_W'(MAX_CHARS))
            code = ST_BAD_LEN;
        else if (bad_char_reg)
            code = ST_BAD_CHAR;
        else if (ovf_reg)
            code = ST_OVERFLOW;
        else if (lead_ones_reg == '0 ? zcnt_reg != '0 : zcnt_reg != lead_ones_reg)
            code = ST_NONCANON;
        else
            code = ST_OK;
    end

    assign stat.last = last_reg;
    assign stat.fail = (code != ST_OK);
    assign out_byte  = cmd.show_ok ? acc_reg[ACC_WORDS-1][63:56] : 8'd0;
    assign status    = cmd.show_err ? code : ST_OK;

endmodule

[hw/rtl/b58d_ctrl.sv]
// Controller: sequences the word steps of each beat, the check and the byte or error output.
// Depends on b58d_pkg.
module b58d_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  b58d_pkg::stat_t    stat,
    output b58d_pkg::cmd_t     cmd,
    output logic               busy,
    output logic               strobe,
    output logic               last_of_run
);
    import b58d_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_ERR   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              byte_end;

    assign byte_end = (byte_reg == BYTE_W'(OUT_BYTES - 1));

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        byte_next  = byte_reg;
        cmd        = '0;
        cmd.step_idx = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.step = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(ACC_WORDS - 1))
                    state_next = stat.last ? S_CHECK : S_IDLE;
            end
            S_CHECK:
            begin
                byte_next  = '0;
                state_next = stat.fail ? S_ERR : S_EMIT;
            end
            S_EMIT:
            begin
                cmd.show_ok = 1'b1;
                cmd.shift   = 1'b1;
                byte_next   = byte_reg + 1'b1;
                if (byte_end)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ERR:
            begin
                cmd.show_err = 1'b1;
                cmd.clear    = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            byte_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            byte_reg  <= byte_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign strobe      = (state_reg == S_EMIT) || (state_reg == S_ERR);
    assign last_of_run = (state_reg == S_ERR) || (state_reg == S_EMIT && byte_end);

endmodule

[hw/rtl/b58d_chk.sv]
// Port-level checker for the Base58 decoder, bound to the top level.
// Depends on b58d_pkg and base58_fixed64_decoder.
module b58d_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       strobe,
    input logic [7:0] out_byte,
    input logic [2:0] status,
    input logic       last_of_run
);
    import b58d_pkg::*;

    // results only come out while the block is occupied
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result shown while idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // an error is always a single beat with a zero byte
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && status != ST_OK) |-> (last_of_run && out_byte == 8'd0))
        else $error("error beat malformed");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_of_run) |=> (!strobe && !busy))
        else $error("output continued after end of run");

endmodule

bind base58_fixed64_decoder b58d_chk u_b58d_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .strobe      (strobe),
    .out_byte    (out_byte),
    .status      (status),
    .last_of_run (last_of_run)
);
